[hw/rtl/ecov_pkg.sv]
// Shared types and constants for the ellipse coverage pipeline.
package ecov_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAJOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MINOR = 1'b1;

  // Coverage format
  localparam int COV_W = 8;
  localparam logic [COV_W-1:0] COV_FULL = '1;
  localparam logic [COV_W-1:0] COV_NONE = '0;

  typedef logic [COV_W-1:0] cov_t;

endpackage

[hw/rtl/ellipse_coverage_antialiased.sv]
// Top level of the antialiased ellipse coverage pipeline.
//
// Takes one pixel offset (x, y) per transfer and returns one 8-bit coverage
// per transfer, in order, against an axis-aligned ellipse whose semi-axes are
// set through the cfg_ port (index 0: axis along x, index 1: axis along y,
// same fixed-point format as the offsets). Coverage is 255 inside, ramps down
// over one edge width outside, and is 0 far away or when either axis is zero.
// Throughput is one item per clock while out_ready keeps the pipe moving; the
// pipe holds the square root chain, one cell per root bit (2*COORD_WIDTH+1
// cells), and the eight-cell quotient chain. Each stage
// moves on when its successor is empty or moving, so bubbles close up and new
// items enter while a finished result waits on out_ready. Write the axes only
// while no transfer is in flight.
module ellipse_coverage_antialiased #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_offset_x,
  input  logic signed [COORD_WIDTH-1:0]   in_offset_y,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ecov_pkg::COV_W-1:0]      out_coverage,
  // configuration
  input  logic                            cfg_we,
  input  logic [ecov_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_wdata
);

  localparam int W     = COORD_WIDTH;
  localparam int CW    = ecov_pkg::COV_W;
  localparam int RW    = 2*W + 1;        // root width
  localparam int RADW  = 2*RW;           // radicand width, padded to pairs
  localparam int PW    = RW + W;         // excess * lesser axis
  localparam int NW    = PW + CW;        // numerator after the 255 scale
  localparam int DW    = 2*W + FRAC_BITS;
  // stage indexes
  localparam int K_IN  = 0;
  localparam int K_P   = 1;
  localparam int K_SQ  = 2;
  localparam int K_RAD = 3;
  localparam int K_S   = K_RAD + RW;
  localparam int K_E   = K_S + 1;
  localparam int K_M   = K_E + 1;
  localparam int K_N   = K_M + 1;
  localparam int K_D   = K_N + CW;
  localparam int K_OUT = K_D + 1;
  localparam int NST   = K_OUT + 1;
  localparam int NFULL = K_D - K_E + 1;

  // configuration registers and values derived from them
  logic [W-1:0]    axis_major_r, axis_minor_r;
  logic [2*W-1:0]  ab_r;
  logic [W-1:0]    lesser_r;
  logic [DW-1:0]   denom_r;
  logic            zero_r;

  // flow control
  logic [NST-1:0]  v_r;
  logic [NST:0]    en;

  // datapath stage registers
  logic [W-1:0]    mx_r, my_r;
  logic [2*W-1:0]  p_r, q_r;
  logic [4*W-1:0]  pp_r, qq_r;
  logic [RADW-1:0] rad_r;
  logic [RW-1:0]   ex_r;
  logic [PW-1:0]   prod_r;
  logic [NW-1:0]   num_r;
  logic [NFULL-1:0] full_r;
  ecov_pkg::cov_t  cov_r;

  // square root chain taps, index 0 is the seed
  logic [RADW-1:0] sq_rad  [0:RW];
  logic [RW:0]     sq_rem  [0:RW];
  logic [RW-1:0]   sq_root [0:RW];

  // quotient chain taps, index 0 is the seed
  logic [NW-1:0]   dv_rem  [0:CW];
  ecov_pkg::cov_t  dv_t    [0:CW];

  logic [W-1:0]    mx_nxt, my_nxt;
  logic            full_nxt;
  ecov_pkg::cov_t  cov_nxt;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_major_r <= '0;
      axis_minor_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ecov_pkg::REG_AXIS_MAJOR: axis_major_r <= cfg_wdata;
        ecov_pkg::REG_AXIS_MINOR: axis_minor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Derived axis terms are registered from the axis registers; they are only read
  // deep in the pipe, long after any item that follows a write.
  always_ff @(posedge clk) begin
    ab_r     <= axis_major_r * axis_minor_r;
    lesser_r <= (axis_major_r < axis_minor_r) ? axis_major_r : axis_minor_r;
    denom_r  <= DW'(axis_major_r * axis_minor_r) << FRAC_BITS;
    zero_r   <= (axis_major_r == '0) || (axis_minor_r == '0);
  end

  // ----------------------------------------------------------- flow control
  // A stage advances when it is empty or its successor advances.
  assign en[NST] = out_ready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  // ---------------------------------------------------------- front stages
  // Take magnitudes; the most negative offset maps exactly to 2^(W-1).
  always_comb begin
    mx_nxt = in_offset_x[W-1] ? (~in_offset_x + W'(1)) : in_offset_x;
    my_nxt = in_offset_y[W-1] ? (~in_offset_y + W'(1)) : in_offset_y;
  end

  always_ff @(posedge clk) begin
    if (en[K_IN]) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
    // X*B and Y*A, then square each: X^2 B^2 + Y^2 A^2
    if (en[K_P]) begin
      p_r <= mx_r * axis_minor_r;
      q_r <= my_r * axis_major_r;
    end
    if (en[K_SQ]) begin
      pp_r <= p_r * p_r;
      qq_r <= q_r * q_r;
    end
    if (en[K_RAD]) begin
      rad_r <= RADW'(pp_r) + RADW'(qq_r);
    end
  end

  // ------------------------------------------------------ square root chain
  assign sq_rad[0]  = rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    ecov_sqrt_cell #(.RW(RW)) u_cell (
      .clk    (clk),
      .ld     (en[K_RAD+1+i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // ---------------------------------------------------------- edge ramp
  // Inside when S <= A*B; otherwise scale the excess by min(A,B)*255.
  assign full_nxt = (sq_root[RW] <= RW'(ab_r));

  always_ff @(posedge clk) begin
    if (en[K_E]) ex_r   <= sq_root[RW] - RW'(ab_r);
    if (en[K_M]) prod_r <= ex_r * lesser_r;
    if (en[K_N]) num_r  <= {prod_r, CW'(0)} - NW'(prod_r);
  end

  // carry the inside flag alongside the ramp and quotient stages
  always_ff @(posedge clk) begin
    if (en[K_E]) full_r[0] <= full_nxt;
    for (int j = 1; j < NFULL; j++) begin
      if (en[K_E+j]) full_r[j] <= full_r[j-1];
    end
  end

  // --------------------------------------------------------- quotient chain
  // Greedy bit search from the top gives min(255, floor(num / denom)).
  assign dv_rem[0] = num_r;
  assign dv_t[0]   = '0;

  for (genvar i = 0; i < CW; i++) begin : g_div
    ecov_div_cell #(.NW(NW), .DW(DW), .BIT(CW-1-i)) u_cell (
      .clk   (clk),
      .ld    (en[K_N+1+i]),
      .rem_i (dv_rem[i]),
      .t_i   (dv_t[i]),
      .den_i (denom_r),
      .rem_o (dv_rem[i+1]),
      .t_o   (dv_t[i+1])
    );
  end

  // ----------------------------------------------------------- output
  always_comb begin
    if (zero_r) begin
      cov_nxt = ecov_pkg::COV_NONE;
    end else if (full_r[NFULL-1]) begin
      cov_nxt = ecov_pkg::COV_FULL;
    end else begin
      cov_nxt = ecov_pkg::COV_FULL - dv_t[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[K_OUT]) cov_r <= cov_nxt;
  end

  assign out_coverage = cov_r;

`ifndef SYNTHESIS
  // an empty output register lets every stage advance
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // an inside item with live axes lands as full coverage
  a_full_cov: assert property (@(posedge clk) disable iff (!rst_n)
    (en[K_OUT] && v_r[K_D] && full_r[NFULL-1] && !zero_r)
      |=> (out_coverage == ecov_pkg::COV_FULL))
    else $error("inside item did not give full coverage");

  // the root chain leaves a remainder no larger than twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[K_S] |-> (sq_rem[RW] <= {sq_root[RW], 1'b0}))
    else $error("square root remainder out of range");
`endif

endmodule

[hw/rtl/ecov_sqrt_cell.sv]
// One step of the digit-by-digit square root: one root bit per cell.
module ecov_sqrt_cell #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            ld,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] rad_o,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   root_o
);

  logic [RW+2:0]   cur;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            ge;
  logic [2*RW-1:0] rad_nxt, rad_r;
  logic [RW:0]     rem_nxt, rem_r;
  logic [RW-1:0]   root_nxt, root_r;

  // bring down the next radicand pair and try root*4+1
  assign cur   = {rem_i, rad_i[2*RW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_comb begin
    rad_nxt  = {rad_i[2*RW-3:0], 2'b00};
    rem_nxt  = ge ? diff[RW:0] : cur[RW:0];
    root_nxt = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

[hw/rtl/ecov_div_cell.sv]
// One restoring division step: settles one quotient bit per cell.
module ecov_div_cell #(
  parameter int NW  = 57,
  parameter int DW  = 36,
  parameter int BIT = 7
) (
  input  logic                    clk,
  input  logic                    ld,
  input  logic [NW-1:0]           rem_i,
  input  logic [ecov_pkg::COV_W-1:0] t_i,
  input  logic [DW-1:0]           den_i,
  output logic [NW-1:0]           rem_o,
  output logic [ecov_pkg::COV_W-1:0] t_o
);

  logic [NW-1:0]              sh;
  logic                       ge;
  logic [NW-1:0]              rem_nxt, rem_r;
  logic [ecov_pkg::COV_W-1:0] t_nxt, t_r;

  assign sh = NW'(den_i) << BIT;
  assign ge = (sh <= rem_i);

  always_comb begin
    rem_nxt = ge ? (rem_i - sh) : rem_i;
    t_nxt   = t_i | (ge ? (ecov_pkg::COV_W'(1) << BIT) : ecov_pkg::COV_W'(0));
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rem_r <= rem_nxt;
      t_r   <= t_nxt;
    end
  end

  assign rem_o = rem_r;
  assign t_o   = t_r;

endmodule

[tb/sv/testbench.sv]
// Testbench for the antialiased ellipse coverage pipeline.
`timescale 1ns / 1ps

// Holds the semi-axes in use and the coverage values still owed by the block.
class coverage_board;
  bit [15:0]       axis_a;
  bit [15:0]       axis_b;
  ecov_pkg::cov_t  owed[$];
  int              errors;
  int              matched;
  int              inside_hits;
  int              ramp_hits;
  int              zero_hits;

  function void set_axis(logic [ecov_pkg::CFG_IDX_W-1:0] idx, bit [15:0] val);
    if (idx == ecov_pkg::REG_AXIS_MAJOR) axis_a = val;
    else axis_b = val;
  endfunction

  // Exact integer coverage: root of X^2B^2 + Y^2A^2 against A*B, floor ramp.
  function ecov_pkg::cov_t coverage_of(bit [15:0] ox, bit [15:0] oy);
    bit [16:0]  mx;
    bit [16:0]  my;
    bit [127:0] radicand;
    bit [127:0] cand;
    bit [63:0]  root;
    bit [63:0]  prod_ab;
    bit [63:0]  excess;
    bit [63:0]  lesser;
    bit [127:0] ramp;
    if (axis_a == 0 || axis_b == 0) return ecov_pkg::COV_NONE;
    mx = ox[15] ? 17'h10000 - {1'b0, ox} : {1'b0, ox};
    my = oy[15] ? 17'h10000 - {1'b0, oy} : {1'b0, oy};
    radicand = 128'(mx) * mx * axis_b * axis_b + 128'(my) * my * axis_a * axis_a;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = 128'(root | (64'd1 << i));
      if (cand * cand <= radicand) root = root | (64'd1 << i);
    end
    prod_ab = 64'(axis_a) * axis_b;
    if (root <= prod_ab) return ecov_pkg::COV_FULL;
    excess = root - prod_ab;
    lesser = axis_a < axis_b ? axis_a : axis_b;
    ramp = (128'(excess) * 255 * lesser) / (128'(prod_ab) << 4);
    if (ramp >= 255) return ecov_pkg::COV_NONE;
    return ecov_pkg::cov_t'(255 - ramp);
  endfunction

  function void note_offset(bit [15:0] ox, bit [15:0] oy);
    owed.push_back(coverage_of(ox, oy));
  endfunction

  function void check_coverage(ecov_pkg::cov_t got);
    ecov_pkg::cov_t want;
    if (owed.size() == 0) begin
      $display("%0t: unexpected coverage transfer, expected none, actual %0d", $time, got);
      errors++;
      return;
    end
    want = owed.pop_front();
    if (got !== want) begin
      $display("%0t: coverage mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end else begin
      matched++;
      if (got == ecov_pkg::COV_FULL) inside_hits++;
      else if (got == ecov_pkg::COV_NONE) zero_hits++;
      else ramp_hits++;
    end
  endfunction
endclass

module testbench;
  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic signed [15:0]             in_offset_x;
  logic signed [15:0]             in_offset_y;
  logic                           out_valid;
  logic                           out_ready;
  logic [ecov_pkg::COV_W-1:0]     out_coverage;
  logic                           cfg_we;
  logic [ecov_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_wdata;

  coverage_board board;
  bit  burst_mode;   // no gaps on either side while set
  bit  hold_req;     // ask the receiver for one long hold-off
  int  sent;

  ellipse_coverage_antialiased uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one offset and hold it until the transfer; valid stays up on return.
  task automatic send_offset(bit [15:0] ox, bit [15:0] oy);
    int idle;
    idle = gap_len();
    if (idle > 0) begin
      in_valid = 0;
      repeat (idle) @(negedge clk);
    end
    in_valid    = 1;
    in_offset_x = ox;
    in_offset_y = oy;
    do @(posedge clk); while (!in_ready);
    board.note_offset(ox, oy);
    sent++;
    @(negedge clk);
  endtask

  // Drain the pipeline fully before touching the axes.
  task automatic settle();
    in_valid = 0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_axis(logic [ecov_pkg::CFG_IDX_W-1:0] idx, bit [15:0] val);
    @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    board.set_axis(idx, val);
  endtask

  // Random offset: mostly near the rim so the ramp gets exercised.
  task automatic random_offsets(int count);
    int spanx;
    int spany;
    bit [15:0] ox;
    bit [15:0] oy;
    spanx = board.axis_a * 2 + 32;
    spany = board.axis_b * 2 + 32;
    if (spanx > 32767) spanx = 32767;
    if (spany > 32767) spany = 32767;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        ox = 16'($urandom);
        oy = 16'($urandom);
      end else begin
        ox = 16'($signed($urandom_range(0, 2 * spanx)) - spanx);
        oy = 16'($signed($urandom_range(0, 2 * spany)) - spany);
      end
      send_offset(ox, oy);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready = 0;
      end else if (!burst_mode && $urandom_range(0, 4) == 0) begin
        stall = gap_len();
        out_ready = (stall == 0);
      end else begin
        out_ready = 1;
      end
    end
  end

  // Check every coverage transfer against the oldest owed value.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_coverage(out_coverage);
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    bit [15:0] edge_pts[6];
    board = new();
    in_valid = 0;
    in_offset_x = 0;
    in_offset_y = 0;
    cfg_we = 0;
    cfg_index = ecov_pkg::REG_AXIS_MAJOR;
    cfg_wdata = 0;
    burst_mode = 0;
    hold_req = 0;
    sent = 0;
    rst_n = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // Axes at reset are zero: coverage must be zero everywhere.
    send_offset(16'h0000, 16'h0000);
    send_offset(16'h8000, 16'h7fff);
    settle();

    // One axis zero, the other not.
    write_axis(ecov_pkg::REG_AXIS_MAJOR, 16'd160);
    send_offset(16'h0000, 16'h0000);
    send_offset(16'd10, 16'd10);
    settle();

    // Directed: centre, rim, just outside, far out, most negative offsets.
    write_axis(ecov_pkg::REG_AXIS_MINOR, 16'd96);
    edge_pts = '{16'd160, 16'd161, 16'd170, 16'hff60, 16'h8000, 16'h7fff};
    send_offset(16'h0000, 16'h0000);
    foreach (edge_pts[i]) send_offset(edge_pts[i], 16'h0000);
    send_offset(16'h0000, 16'd96);
    send_offset(16'h0000, 16'd97);
    send_offset(16'h0000, 16'hffa0);
    send_offset(16'h0000, 16'h8000);
    send_offset(16'h8000, 16'h8000);
    send_offset(16'h7fff, 16'h7fff);
    send_offset(16'd120, 16'd70);
    send_offset(16'hff88, 16'hffb8);
    settle();

    // Largest axes: everything lands inside, including the extremes.
    write_axis(ecov_pkg::REG_AXIS_MAJOR, 16'hffff);
    write_axis(ecov_pkg::REG_AXIS_MINOR, 16'hffff);
    send_offset(16'h8000, 16'h8000);
    send_offset(16'h7fff, 16'h8000);
    random_offsets(150);
    settle();

    // Smallest axes: a tiny ellipse, steepest ramp.
    write_axis(ecov_pkg::REG_AXIS_MAJOR, 16'd1);
    write_axis(ecov_pkg::REG_AXIS_MINOR, 16'd1);
    send_offset(16'd1, 16'd0);
    send_offset(16'd1, 16'd1);
    send_offset(16'd2, 16'd0);
    random_offsets(200);
    settle();

    // Long receiver hold-off with the sender running flat out.
    write_axis(ecov_pkg::REG_AXIS_MAJOR, 16'd320);
    write_axis(ecov_pkg::REG_AXIS_MINOR, 16'd200);
    burst_mode = 1;
    hold_req = 1;
    random_offsets(200);
    burst_mode = 0;
    random_offsets(100);
    settle();

    // Random axis settings, wide and narrow, with gaps on and off.
    for (int p = 0; p < 6; p++) begin
      write_axis(ecov_pkg::REG_AXIS_MAJOR,
                 p[0] ? 16'($urandom_range(1, 4000)) : 16'($urandom));
      write_axis(ecov_pkg::REG_AXIS_MINOR,
                 p[1] ? 16'($urandom_range(1, 600)) : 16'($urandom_range(1, 60000)));
      burst_mode = (p == 2);
      random_offsets(200);
      burst_mode = 0;
      settle();
    end

    // Narrow ellipse with a maximal cross axis.
    write_axis(ecov_pkg::REG_AXIS_MAJOR, 16'd8);
    write_axis(ecov_pkg::REG_AXIS_MINOR, 16'hffff);
    random_offsets(50);
    settle();

    $display("Covered %0d offsets over 13 axis settings: %0d inside, %0d on the ramp, %0d zero.",
             sent, board.inside_hits, board.ramp_hits, board.zero_hits);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
